>>> rtl/binary_min_heap_queue_assert.svh
// Assertion macros used by the heap queue checker.
// Each macro expects i_clk and i_rst_n in the scope where it is used.
`ifndef BINARY_MIN_HEAP_QUEUE_ASSERT_SVH
`define BINARY_MIN_HEAP_QUEUE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BHQ_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define BHQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/bhq_pkg.sv
package bhq_pkg;

    // Field widths of one entry, of the capacity register and of the count output.
    localparam int KEY_W     = 32;
    localparam int VID_W     = 16;
    localparam int CAP_W     = 7;
    localparam int CNT_OUT_W = 7;

    localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

    // Action codes of an input item.
    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_DELETE = 1'b1;

    // One heap entry: priority key and vehicle id.
    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [VID_W-1:0] vid;
    } t_entry;

    // The two children of one parent, as read from a level.
    typedef struct packed {
        t_entry left;
        t_entry right;
    } t_pair;

    // Operation token handed from one level cell to the next.
    typedef struct packed {
        logic   valid;
        logic   del;
        logic   disp;
        t_entry ent;
    } t_token;

    // Write event of a level cell.
    typedef struct packed {
        logic   en;
        t_entry ent;
    } t_wr;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FETCH,
        ST_LOAD,
        ST_RUN,
        ST_DONE
    } t_state;

endpackage

>>> rtl/bhq_if.sv
// Request channel: one item per insert or delete.
interface bhq_in_if;
    logic                       valid;
    logic                       ready;
    logic                       action;
    logic [bhq_pkg::KEY_W-1:0]  key_time;
    logic [bhq_pkg::VID_W-1:0]  vehicle_id;

    modport source (output valid, action, key_time, vehicle_id, input ready);
    modport sink   (input valid, action, key_time, vehicle_id, output ready);
endinterface

// Result channel: one item per request.
interface bhq_out_if;
    logic                          valid;
    logic                          ready;
    logic                          ok;
    logic [bhq_pkg::CNT_OUT_W-1:0] entry_count;
    logic                          min_valid;
    logic [bhq_pkg::KEY_W-1:0]     min_time;
    logic [bhq_pkg::VID_W-1:0]     min_vehicle;

    modport source (output valid, ok, entry_count, min_valid, min_time, min_vehicle,
                    input ready);
    modport sink   (input valid, ok, entry_count, min_valid, min_time, min_vehicle,
                    output ready);
endinterface

>>> rtl/binary_min_heap_queue.sv
// An insert passes its token down the level cells to the new slot; a delete first
// fetches the last entry, then passes its token down until the hole settles; a refused
// item goes straight to the result register, which holds each result until it is taken.
// Only one item is in work at a time: a new item is taken only once the result of the
// last one has been loaded, which waits while an earlier result still waits for ready.
// Reset (synchronous, active low) empties the queue and sets capacity to 64.
module binary_min_heap_queue #(
    parameter int HEAP_DEPTH = 64
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [bhq_pkg::CAP_W-1:0]  i_cfg_wdata,
    bhq_in_if.sink                     i_req,
    bhq_out_if.source                  o_rsp
);

    localparam int NODE_W  = $clog2(HEAP_DEPTH + 1);
    localparam int LVL_W   = $clog2(NODE_W);
    localparam int NUM_LVL = NODE_W;
    localparam int CMP_W   = (NODE_W > bhq_pkg::CAP_W) ? NODE_W : bhq_pkg::CAP_W;
    localparam logic [CMP_W-1:0] DEPTH_C = CMP_W'(HEAP_DEPTH);

    bhq_pkg::t_state r_state;
    bhq_pkg::t_state n_state;

    logic [bhq_pkg::CAP_W-1:0] r_cap;
    logic [NODE_W-1:0]         r_count;
    logic                      r_ok;
    logic [NODE_W-1:0]         r_fetch_node;
    logic [NODE_W-1:0]         r_target;
    logic [LVL_W-1:0]          r_tlevel;
    bhq_pkg::t_token           r_tok0;
    bhq_pkg::t_entry           r_root;

    logic                          r_out_vld;
    logic                          r_out_ok;
    logic [bhq_pkg::CNT_OUT_W-1:0] r_out_cnt;
    logic                          r_out_mv;
    logic [bhq_pkg::KEY_W-1:0]     r_out_time;
    logic [bhq_pkg::VID_W-1:0]     r_out_vid;

    logic [CMP_W-1:0]  eff_cap;
    logic              can_ins;
    logic              can_del;
    logic [NODE_W-1:0] tgt;
    logic [LVL_W-1:0]  tgt_lvl;
    logic              accept;
    logic              fetch_vld;
    logic              load_out;
    logic              any_done;
    bhq_pkg::t_entry   last_ent;

    // Chain links between the level cells.
    bhq_pkg::t_token   tok       [NUM_LVL+1];
    logic [NODE_W-1:0] tok_node  [NUM_LVL+1];
    logic              creq_vld  [NUM_LVL+1];
    logic [NODE_W-1:0] creq_node [NUM_LVL+1];
    bhq_pkg::t_pair    child     [NUM_LVL+1];
    logic              fetch_hit [NUM_LVL];
    bhq_pkg::t_entry   fetch_ent [NUM_LVL];
    logic              done      [NUM_LVL];
    bhq_pkg::t_wr      wr        [NUM_LVL];

    assign tok[0]           = r_tok0;
    assign tok_node[0]      = NODE_W'(1);
    assign creq_vld[0]      = 1'b0;
    assign creq_node[0]     = '0;
    assign child[NUM_LVL]   = '0;

    for (genvar k = 0; k < NUM_LVL; k++) begin : g_lvl
        bhq_cell #(
            .NODE_W  (NODE_W),
            .LVL_W   (LVL_W),
            .LEVEL   (k),
            .IS_LAST (k == NUM_LVL - 1)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_tok        (tok[k]),
            .i_tok_node   (tok_node[k]),
            .o_tok        (tok[k+1]),
            .o_tok_node   (tok_node[k+1]),
            .i_count      (r_count),
            .i_target     (r_target),
            .i_tlevel     (r_tlevel),
            .i_fetch_vld  (fetch_vld),
            .i_fetch_node (r_fetch_node),
            .o_fetch_hit  (fetch_hit[k]),
            .o_fetch_ent  (fetch_ent[k]),
            .i_creq_vld   (creq_vld[k]),
            .i_creq_node  (creq_node[k]),
            .o_child      (child[k]),
            .o_creq_vld   (creq_vld[k+1]),
            .o_creq_node  (creq_node[k+1]),
            .i_child      (child[k+1]),
            .o_done       (done[k]),
            .o_wr         (wr[k])
        );
    end

    // Capacity check, new slot number and its level.
    always_comb begin
        eff_cap = (CMP_W'(r_cap) > DEPTH_C) ? DEPTH_C : CMP_W'(r_cap);
        can_ins = CMP_W'(r_count) < eff_cap;
        can_del = (r_count != '0);
        tgt     = r_count + NODE_W'(1);
        tgt_lvl = '0;
        for (int b = 0; b < NODE_W; b++) begin
            if (tgt[b]) begin
                tgt_lvl = LVL_W'(b);
            end
        end
    end

    // Collect the fetched last entry and the completion of the operation.
    always_comb begin
        last_ent = '0;
        any_done = 1'b0;
        for (int k = 0; k < NUM_LVL; k++) begin
            if (fetch_hit[k]) begin
                last_ent = fetch_ent[k];
            end
            any_done = any_done | done[k];
        end
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bhq_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and strobes.
    always_comb begin
        n_state   = r_state;
        accept    = 1'b0;
        fetch_vld = 1'b0;
        load_out  = 1'b0;
        case (r_state)
            bhq_pkg::ST_IDLE: begin
                accept = i_req.valid;
                if (i_req.valid) begin
                    if (i_req.action == bhq_pkg::ACT_INSERT) begin
                        n_state = can_ins ? bhq_pkg::ST_RUN : bhq_pkg::ST_DONE;
                    end else begin
                        n_state = can_del ? bhq_pkg::ST_FETCH : bhq_pkg::ST_DONE;
                    end
                end
            end
            bhq_pkg::ST_FETCH: begin
                fetch_vld = 1'b1;
                n_state   = bhq_pkg::ST_LOAD;
            end
            bhq_pkg::ST_LOAD: begin
                n_state = (r_count != '0) ? bhq_pkg::ST_RUN : bhq_pkg::ST_DONE;
            end
            bhq_pkg::ST_RUN: begin
                if (any_done) begin
                    n_state = bhq_pkg::ST_DONE;
                end
            end
            bhq_pkg::ST_DONE: begin
                if (!r_out_vld || o_rsp.ready) begin
                    load_out = 1'b1;
                    n_state  = bhq_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = bhq_pkg::ST_IDLE;
            end
        endcase
    end

    // Control registers: capacity, count and the token into the root cell.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap   <= bhq_pkg::CAP_RESET;
            r_count <= '0;
            r_tok0  <= '0;
        end else begin
            if (i_cfg_we) begin
                r_cap <= i_cfg_wdata;
            end
            if (accept) begin
                if (i_req.action == bhq_pkg::ACT_INSERT) begin
                    if (can_ins) begin
                        r_count <= tgt;
                    end
                end else if (can_del) begin
                    r_count <= r_count - NODE_W'(1);
                end
            end
            // The root token lives for one cycle: an insert at acceptance, a delete
            // once the last entry has been fetched.
            if (accept && (i_req.action == bhq_pkg::ACT_INSERT) && can_ins) begin
                r_tok0.valid <= 1'b1;
                r_tok0.del   <= 1'b0;
                r_tok0.disp  <= 1'b0;
                r_tok0.ent   <= {i_req.key_time, i_req.vehicle_id};
            end else if (!accept && (r_state == bhq_pkg::ST_LOAD) && (r_count != '0)) begin
                r_tok0.valid <= 1'b1;
                r_tok0.del   <= 1'b1;
                r_tok0.disp  <= 1'b0;
                r_tok0.ent   <= last_ent;
            end else begin
                r_tok0.valid <= 1'b0;
            end
        end
    end

    // Operation context and the copy of the root entry.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_ok         <= (i_req.action == bhq_pkg::ACT_INSERT) ? can_ins : can_del;
            r_target     <= tgt;
            r_tlevel     <= tgt_lvl;
            r_fetch_node <= r_count;
        end
        if (wr[0].en) begin
            r_root <= wr[0].ent;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (load_out) begin
            r_out_vld <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_vld <= 1'b0;
        end
        if (load_out) begin
            r_out_ok   <= r_ok;
            r_out_cnt  <= bhq_pkg::CNT_OUT_W'(r_count);
            r_out_mv   <= (r_count != '0);
            r_out_time <= (r_count != '0) ? r_root.key : '0;
            r_out_vid  <= (r_count != '0) ? r_root.vid : '0;
        end
    end

    assign i_req.ready       = (r_state == bhq_pkg::ST_IDLE);
    assign o_rsp.valid       = r_out_vld;
    assign o_rsp.ok          = r_out_ok;
    assign o_rsp.entry_count = r_out_cnt;
    assign o_rsp.min_valid   = r_out_mv;
    assign o_rsp.min_time    = r_out_time;
    assign o_rsp.min_vehicle = r_out_vid;

endmodule

>>> rtl/bhq_cell.sv
// One level of the heap. The cell owns the entries of its level and works on
// the operation token: it reads in the arrival cycle and
// compares and writes in the following cycle, then hands the token on.
module bhq_cell #(
    parameter int   NODE_W  = 7,
    parameter int   LVL_W   = 3,
    parameter int   LEVEL   = 0,
    parameter logic IS_LAST = 1'b0
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Token from the level above.
    input  bhq_pkg::t_token       i_tok,
    input  logic [NODE_W-1:0]     i_tok_node,
    // Token to the level below.
    output bhq_pkg::t_token       o_tok,
    output logic [NODE_W-1:0]     o_tok_node,
    // Operation context.
    input  logic [NODE_W-1:0]     i_count,
    input  logic [NODE_W-1:0]     i_target,
    input  logic [LVL_W-1:0]      i_tlevel,
    // Fetch of the last entry before a delete.
    input  logic                  i_fetch_vld,
    input  logic [NODE_W-1:0]     i_fetch_node,
    output logic                  o_fetch_hit,
    output bhq_pkg::t_entry       o_fetch_ent,
    // Child read requested by the level above.
    input  logic                  i_creq_vld,
    input  logic [NODE_W-1:0]     i_creq_node,
    output bhq_pkg::t_pair        o_child,
    // Child read toward the level below.
    output logic                  o_creq_vld,
    output logic [NODE_W-1:0]     o_creq_node,
    input  bhq_pkg::t_pair        i_child,
    // Status.
    output logic                  o_done,
    output bhq_pkg::t_wr          o_wr
);

    localparam int AW      = (LEVEL > 0) ? LEVEL : 1;
    localparam int DEPTH_L = 2 ** AW;
    localparam logic [NODE_W-1:0] LVL_MASK = NODE_W'((64'd1 << LEVEL) - 64'd1);
    localparam logic [LVL_W-1:0]  LVL_ID   = LVL_W'(LEVEL);

    bhq_pkg::t_entry r_mem [DEPTH_L];
    bhq_pkg::t_entry r_rd_a;
    bhq_pkg::t_entry r_rd_b;

    bhq_pkg::t_token r_tok;
    logic [NODE_W-1:0] r_node;
    bhq_pkg::t_token r_out_tok;
    logic [NODE_W-1:0] r_out_node;
    logic r_fetch_hit;

    logic [NODE_W-1:0] ins_node;
    logic [NODE_W-1:0] child_l;
    logic [NODE_W-1:0] child_r;
    logic [AW-1:0]     addr_a;
    logic [AW-1:0]     addr_b;
    logic              fetch_here;

    logic [NODE_W:0]   p2;
    logic [NODE_W:0]   cnt_ext;
    logic              has_l;
    logic              has_r;
    logic              pick_r;
    bhq_pkg::t_entry   pick;
    logic [NODE_W-1:0] q_node;

    logic              wr_en;
    bhq_pkg::t_entry   wr_ent;
    logic [AW-1:0]     wr_addr;
    logic              done;
    bhq_pkg::t_token   n_tok;
    logic [NODE_W-1:0] n_tok_node;

    // Arrival: read addresses for the own path slot, the children or the fetch.
    always_comb begin
        ins_node   = i_target >> (i_tlevel - LVL_ID);
        child_l    = {i_creq_node[NODE_W-2:0], 1'b0};
        child_r    = {i_creq_node[NODE_W-2:0], 1'b1};
        fetch_here = i_fetch_vld && ((i_fetch_node >> LEVEL) == NODE_W'(1));
        if (i_creq_vld) begin
            addr_a = AW'(child_l & LVL_MASK);
        end else if (i_tok.valid && !i_tok.del) begin
            addr_a = AW'(ins_node & LVL_MASK);
        end else begin
            addr_a = AW'(i_fetch_node & LVL_MASK);
        end
        addr_b = AW'(child_r & LVL_MASK);
    end

    // A delete token asks the level below for the children of its slot.
    assign o_creq_vld  = i_tok.valid && i_tok.del && (IS_LAST == 1'b0);
    assign o_creq_node = i_tok_node;

    // Level memory with registered reads.
    always_ff @(posedge i_clk) begin
        r_rd_a <= r_mem[addr_a];
        r_rd_b <= r_mem[addr_b];
        if (wr_en) begin
            r_mem[wr_addr] <= wr_ent;
        end
    end

    // Token capture for the decision cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok       <= '0;
            r_fetch_hit <= 1'b0;
        end else begin
            r_tok       <= i_tok;
            r_fetch_hit <= fetch_here;
        end
        r_node <= i_tok.del ? i_tok_node : ins_node;
    end

    // Decision: compare, write the own slot and pass the token on.
    always_comb begin
        p2      = {r_node, 1'b0};
        cnt_ext = {1'b0, i_count};
        has_l   = (IS_LAST == 1'b0) && (p2 <= cnt_ext);
        has_r   = (IS_LAST == 1'b0) && ((p2 | (NODE_W+1)'(1)) <= cnt_ext);
        pick_r  = has_r && !(i_child.left.key < i_child.right.key);
        pick    = pick_r ? i_child.right : i_child.left;
        q_node  = {r_node[NODE_W-2:0], pick_r};

        wr_en      = 1'b0;
        wr_ent     = r_tok.ent;
        wr_addr    = AW'(r_node & LVL_MASK);
        done       = 1'b0;
        n_tok      = '0;
        n_tok_node = r_node;

        if (r_tok.valid) begin
            if (!r_tok.del) begin
                // Insert walks the path to the new slot, top down.
                if (LVL_ID == i_tlevel) begin
                    wr_en = 1'b1;
                    done  = 1'b1;
                end else if (r_tok.disp || (r_tok.ent.key < r_rd_a.key)) begin
                    wr_en       = 1'b1;
                    n_tok.valid = 1'b1;
                    n_tok.disp  = 1'b1;
                    n_tok.ent   = r_rd_a;
                end else begin
                    n_tok = r_tok;
                end
            end else begin
                // Delete: the hole takes the smaller child while it is smaller.
                wr_en = 1'b1;
                if (has_l && (pick.key < r_tok.ent.key)) begin
                    wr_ent      = pick;
                    n_tok.valid = 1'b1;
                    n_tok.del   = 1'b1;
                    n_tok.ent   = r_tok.ent;
                    n_tok_node  = q_node;
                end else begin
                    done = 1'b1;
                end
            end
        end
    end

    // Token register toward the level below.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_tok <= '0;
        end else begin
            r_out_tok <= n_tok;
        end
        r_out_node <= n_tok_node;
    end

    assign o_tok       = r_out_tok;
    assign o_tok_node  = r_out_node;
    assign o_fetch_hit = r_fetch_hit;
    assign o_fetch_ent = r_rd_a;
    assign o_child     = {r_rd_a, r_rd_b};
    assign o_done      = done;
    assign o_wr        = {wr_en, wr_ent};

endmodule

>>> rtl/bhq_checker.sv
`include "binary_min_heap_queue_assert.svh"

// Port-level checks of the heap queue.
module bhq_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          i_in_ready,
    input logic                          i_out_valid,
    input logic                          i_out_ready,
    input logic                          i_out_ok,
    input logic [bhq_pkg::CNT_OUT_W-1:0] i_out_entry_count,
    input logic                          i_out_min_valid,
    input logic [bhq_pkg::KEY_W-1:0]     i_out_min_time,
    input logic [bhq_pkg::VID_W-1:0]     i_out_min_vehicle
);

    // A stalled result item keeps its contents.
    `BHQ_ASSERT_NEXT(a_out_hold, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_ok) && $stable(i_out_entry_count) && $stable(i_out_min_time) && $stable(i_out_min_vehicle), "result changed while stalled")

    // An empty queue reports a zero count and zero minimum fields.
    `BHQ_ASSERT_NOW(a_empty_min, i_out_valid && !i_out_min_valid, (i_out_entry_count == '0) && (i_out_min_time == '0) && (i_out_min_vehicle == '0), "empty result carries data")

    // Only one item is in work: the request side closes right after an accept.
    `BHQ_ASSERT_NEXT(a_one_item, i_in_valid && i_in_ready, !i_in_ready, "second item taken while busy")

endmodule

bind binary_min_heap_queue bhq_checker u_bhq_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_in_valid        (i_req.valid),
    .i_in_ready        (i_req.ready),
    .i_out_valid       (o_rsp.valid),
    .i_out_ready       (o_rsp.ready),
    .i_out_ok          (o_rsp.ok),
    .i_out_entry_count (o_rsp.entry_count),
    .i_out_min_valid   (o_rsp.min_valid),
    .i_out_min_time    (o_rsp.min_time),
    .i_out_min_vehicle (o_rsp.min_vehicle)
);
